[src/pid_controller_clamped_top_macros.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Property wrappers for the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pidc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller package
// Q16.16 types, register map, configuration bundle and saturating arithmetic.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Q16.16 signed value
    typedef logic signed [31:0] q_t;

    // Configuration bundle from the register file to the datapath
    typedef struct packed {
        q_t   kp;
        q_t   ki_dt;
        q_t   kd_div_dt;
        q_t   out_max;
        q_t   out_min;
        logic deriv_meas;
    } pidc_cfg_t;

    localparam int ADDR_W = 5;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_KP        = 3'd0;
    localparam logic [2:0] REG_KI_DT     = 3'd1;
    localparam logic [2:0] REG_KD_DIV_DT = 3'd2;
    localparam logic [2:0] REG_OUT_MAX   = 3'd3;
    localparam logic [2:0] REG_OUT_MIN   = 3'd4;
    localparam logic [2:0] REG_DERIV     = 3'd5;

    // Item actions
    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    // Clamp a 33-bit result into 32 bits
    function automatic q_t sat33(input logic signed [32:0] v);
        q_t r;
        if (v[32] != v[31])
            r = v[32] ? Q_MIN : Q_MAX;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic q_t add_sat(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        return sat33(s);
    endfunction

    function automatic q_t sub_sat(input q_t a, input q_t b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        return sat33(s);
    endfunction

    // Q16.16 multiply: floor of the product over 2^16, saturated to 32 bits
    function automatic q_t qmul_sat(input q_t a, input q_t b);
        logic signed [63:0] prod;
        q_t r;
        prod = 64'(a) * 64'(b);
        if ((&prod[63:47]) || !(|prod[63:47]))
            r = prod[47:16];
        else
            r = prod[63] ? Q_MIN : Q_MAX;
        return r;
    endfunction

endpackage

[src/pid_controller_clamped_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with clamped output and conditional integration
// Q16.16 control step per input transaction, four-register pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, setpoint, measurement.
//   action 0 runs one control step, action 1 clears the integral, the stored
//   error, measurement and last drive; a clear returns drive 0, at_limit 0.
//   Output channel (out_valid/out_ready) returns one drive/at_limit per item,
//   in order.
//   An accepted item moves through the difference register and the multiply
//   register into the result register, where it raises out_valid.
//   Throughput: one transaction per cycle while out_ready is high; the integral
//   and last-drive recurrence closes inside the final stage.
//   Gains and limits must be written over the APB port only while the block
//   is idle; the block does not enforce this. Reset clears all pipeline
//   valids and the stored state; registers take their defaults (zero gains,
//   full-range limits). When the receiver stalls, the result holds and earlier
//   stages keep filling until every stage is occupied, then in_ready drops.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic signed [31:0]          setpoint,
    input  logic signed [31:0]          measurement,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          drive,
    output logic                        at_limit
);
    import pidc_pkg::*;

    pidc_cfg_t cfg;

    // Stage 1: input register
    logic s1_valid_reg;
    logic s1_act_reg;
    q_t   s1_err_reg;
    q_t   s1_meas_reg;
    // Stage 2: error and difference
    logic s2_valid_reg;
    logic s2_act_reg;
    q_t   s2_err_reg;
    q_t   s2_delta_reg;
    // Stage 3: products
    logic s3_valid_reg;
    logic s3_act_reg;
    logic s3_err_pos_reg;
    logic s3_err_neg_reg;
    q_t   s3_p_reg;
    q_t   s3_ki_reg;
    q_t   s3_d_reg;
    // Result register
    logic out_valid_reg;
    q_t   drive_reg;
    logic at_limit_reg;

    // Stored controller state
    q_t   last_err_reg;
    q_t   last_meas_reg;
    q_t   integral_reg;
    q_t   last_drive_reg;

    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;

    q_t   delta_next;
    q_t   integral_next;
    q_t   sum_pi;
    q_t   sum_all;
    q_t   drive_next;
    logic at_limit_next;
    logic hold_int;

    pidc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Each stage takes new data when empty or when its successor takes its data
    assign out_free = !out_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= in_valid;
    end

    // Capture item and form the error
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_free)
        begin
            s1_act_reg  <= action;
            s1_err_reg  <= sub_sat(setpoint, measurement);
            s1_meas_reg <= measurement;
        end
    end

    // Derivative input: negated change of measurement, or change of error
    always_comb
    begin
        if (cfg.deriv_meas)
            delta_next = sub_sat(last_meas_reg, s1_meas_reg);
        else
            delta_next = sub_sat(s1_err_reg, last_err_reg);
    end

    // Stage 2 valid and previous-sample tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            last_err_reg  <= '0;
            last_meas_reg <= '0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_act_reg == ACT_CLEAR)
                begin
                    last_err_reg  <= '0;
                    last_meas_reg <= '0;
                end
                else
                begin
                    last_err_reg  <= s1_err_reg;
                    last_meas_reg <= s1_meas_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            s2_act_reg   <= s1_act_reg;
            s2_err_reg   <= s1_err_reg;
            s2_delta_reg <= delta_next;
        end
    end

    // Stage 3: three independent products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (s3_free)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            s3_act_reg     <= s2_act_reg;
            s3_err_pos_reg <= (s2_err_reg > 0);
            s3_err_neg_reg <= s2_err_reg[31];
            s3_p_reg       <= qmul_sat(cfg.kp, s2_err_reg);
            s3_ki_reg      <= qmul_sat(cfg.ki_dt, s2_err_reg);
            s3_d_reg       <= qmul_sat(cfg.kd_div_dt, s2_delta_reg);
        end
    end

    // Integrate unless the last drive sits at a limit and the error pushes past it
    assign hold_int = ((last_drive_reg >= cfg.out_max) && s3_err_pos_reg) ||
                      ((last_drive_reg <= cfg.out_min) && s3_err_neg_reg);

    always_comb
    begin
        if (hold_int)
            integral_next = integral_reg;
        else
            integral_next = add_sat(integral_reg, s3_ki_reg);
        sum_pi  = add_sat(s3_p_reg, integral_next);
        sum_all = add_sat(sum_pi, s3_d_reg);
    end

    // Clamp, upper limit first
    always_comb
    begin
        priority if (sum_all > cfg.out_max)
        begin
            drive_next    = cfg.out_max;
            at_limit_next = 1'b1;
        end
        else if (sum_all < cfg.out_min)
        begin
            drive_next    = cfg.out_min;
            at_limit_next = 1'b1;
        end
        else
        begin
            drive_next    = sum_all;
            at_limit_next = 1'b0;
        end
    end

    // Result valid and recurrent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            integral_reg   <= '0;
            last_drive_reg <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                if (s3_act_reg == ACT_CLEAR)
                begin
                    integral_reg   <= '0;
                    last_drive_reg <= '0;
                end
                else
                begin
                    integral_reg   <= integral_next;
                    last_drive_reg <= drive_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s3_valid_reg)
        begin
            if (s3_act_reg == ACT_CLEAR)
            begin
                drive_reg    <= '0;
                at_limit_reg <= 1'b0;
            end
            else
            begin
                drive_reg    <= drive_next;
                at_limit_reg <= at_limit_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign at_limit  = at_limit_reg;

endmodule

[src/pidc_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style port holding gains, output limits and the derivative source.
// ----------------------------------------------------------------------------
module pidc_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pidc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output pidc_pkg::pidc_cfg_t         cfg
);
    import pidc_pkg::*;

    q_t         kp_reg;
    q_t         ki_dt_reg;
    q_t         kd_div_dt_reg;
    q_t         out_max_reg;
    q_t         out_min_reg;
    logic       deriv_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Write on the access phase of a transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_dt_reg     <= '0;
            kd_div_dt_reg <= '0;
            out_max_reg   <= Q_MAX;
            out_min_reg   <= Q_MIN;
            deriv_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_KP:        kp_reg        <= pwdata;
                REG_KI_DT:     ki_dt_reg     <= pwdata;
                REG_KD_DIV_DT: kd_div_dt_reg <= pwdata;
                REG_OUT_MAX:   out_max_reg   <= pwdata;
                REG_OUT_MIN:   out_min_reg   <= pwdata;
                REG_DERIV:     deriv_reg     <= pwdata[0];
                default:       ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (reg_idx)
            REG_KP:        prdata = kp_reg;
            REG_KI_DT:     prdata = ki_dt_reg;
            REG_KD_DIV_DT: prdata = kd_div_dt_reg;
            REG_OUT_MAX:   prdata = out_max_reg;
            REG_OUT_MIN:   prdata = out_min_reg;
            REG_DERIV:     prdata = {31'd0, deriv_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg = '{kp:         kp_reg,
                   ki_dt:      ki_dt_reg,
                   kd_div_dt:  kd_div_dt_reg,
                   out_max:    out_max_reg,
                   out_min:    out_min_reg,
                   deriv_meas: deriv_reg};

endmodule

[src/pidc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller port checker
// Tracks outstanding transactions and checks result hold, in-flight count and input readiness on the ports.
// ----------------------------------------------------------------------------
`include "pid_controller_clamped_top_macros.svh"

module pidc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] drive,
    input logic               at_limit
);
    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Count accepted transactions not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + 3'd1;
        else if (!in_acc && out_acc)
            pending_next = pending_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= 3'd0;
        else
            pending_reg <= pending_next;
    end

    `PIDC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive) && $stable(at_limit), "stalled result changed")
    `PIDC_ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, pending_reg != 3'd0, "result without a pending transaction")
    `PIDC_ASSERT_IMP(a_depth, clk, rst_n, 1'b1, pending_reg <= 3'd4, "more transactions in flight than pipeline stages")
    `PIDC_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "input blocked while result register is empty")

endmodule

bind pid_controller_clamped_top pidc_checker u_pidc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .at_limit  (at_limit)
);
